[rtl/core/ccd_pkg.sv]
// Shared types, constants and mapping functions of the charset character decoder.
package ccd_pkg;

    localparam int unsigned PendDepth = 5;

    typedef enum logic [2:0] {
        CS_UTF8   = 3'd0,
        CS_ASCII  = 3'd1,
        CS_ISO1   = 3'd2,
        CS_ISO15  = 3'd3,
        CS_CP1252 = 3'd4
    } t_charset;

    localparam logic [0:0] REG_CHARSET = 1'b0;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [30:0] code_point;
        logic        point_valid;
        logic [2:0]  char_bytes;
        logic [1:0]  display_width;
        logic        run_last;
        logic        final_char;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
    } t_ccd_cmd;

    // datapath to controller
    typedef struct packed {
        logic any;
        logic last;
    } t_ccd_sts;

    localparam logic [15:0] Cp1252Low [32] = '{
        16'h20ac, 16'h0000, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
        16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017d, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h00b7, 16'h2013, 16'h2014,
        16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h0000, 16'h017e, 16'h0178
    };

    function automatic logic in_rng(logic [30:0] c, logic [30:0] lo, logic [30:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [1:0] cp_width(logic [30:0] c);
        logic [1:0] w;
        w = 2'd1;
        if (in_rng(c, 31'h00300, 31'h0036F) || in_rng(c, 31'h01AB0, 31'h01AFF) ||
            in_rng(c, 31'h01DC0, 31'h01DFF) || in_rng(c, 31'h0200B, 31'h0200F) ||
            in_rng(c, 31'h0202A, 31'h0202E) || in_rng(c, 31'h02060, 31'h02064))
            w = 2'd0;
        else if (in_rng(c, 31'h02E80, 31'h04DBF) || in_rng(c, 31'h04E00, 31'h09FFF) ||
                 in_rng(c, 31'h0FE30, 31'h0FE4F) || in_rng(c, 31'h0FF00, 31'h0FF60) ||
                 in_rng(c, 31'h0FFE0, 31'h0FFE6) || in_rng(c, 31'h20000, 31'h2FA1F))
            w = 2'd2;
        return w;
    endfunction

    // 1..6 for a lead or ASCII byte, 0 otherwise
    function automatic logic [2:0] lead_len(logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b[7] == 1'b0)                n = 3'd1;
        else if (b[7:5] == 3'b110)       n = 3'd2;
        else if (b[7:4] == 4'b1110)      n = 3'd3;
        else if (b[7:3] == 5'b11110)     n = 3'd4;
        else if (b[7:2] == 6'b111110)    n = 3'd5;
        else if (b[7:1] == 7'b1111110)   n = 3'd6;
        return n;
    endfunction

    // {valid, code point} for the single-byte charsets
    function automatic logic [16:0] sb_map(logic [2:0] cs, logic [7:0] b);
        logic [15:0] cp;
        logic        ok;
        cp = 16'd0;
        ok = 1'b0;
        case (cs)
            CS_ASCII: begin
                cp = {9'd0, b[6:0]};
                ok = 1'b1;
            end
            CS_ISO1, CS_ISO15, CS_CP1252: begin
                if (b < 8'h80) begin
                    cp = {8'd0, b};
                end else if (b < 8'hA0) begin
                    cp = (cs == CS_CP1252) ? Cp1252Low[b[4:0]] : 16'd0;
                end else if (b != 8'hAD) begin
                    cp = {8'd0, b};
                    if (cs == CS_ISO15) begin
                        case (b)
                            8'hA4: cp = 16'h20ac;
                            8'hA6: cp = 16'h0160;
                            8'hA8: cp = 16'h0161;
                            8'hB4: cp = 16'h017d;
                            8'hB8: cp = 16'h017e;
                            8'hBC: cp = 16'h0152;
                            8'hBD: cp = 16'h0153;
                            8'hBE: cp = 16'h0178;
                            default: cp = {8'd0, b};
                        endcase
                    end
                end
                ok = (b < 8'h80) || (cp != 16'd0);
            end
            default: begin
                cp = 16'd0;
                ok = 1'b0;
            end
        endcase
        return {ok, cp};
    endfunction

endpackage

[rtl/core/ccd_ctrl.sv]
// Controller of the charset character decoder: accept, then deliver results.
module ccd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ccd_pkg::t_ccd_sts i_sts,
    output ccd_pkg::t_ccd_cmd o_cmd
);
    import ccd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_EMIT) && i_sts.any;
        o_cmd.load  = o_in_ready && i_in_valid;
        o_cmd.pop   = o_out_valid && i_out_ready;
        n_state     = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_sts.any || (o_cmd.pop && i_sts.last)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/ccd_dpath.sv]
// Datapath of the charset character decoder: byte buffer, decode and result queue.
module ccd_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_charset,
    input  ccd_pkg::t_in_item i_in_item,
    input  ccd_pkg::t_ccd_cmd i_cmd,
    output ccd_pkg::t_ccd_sts o_sts,
    output ccd_pkg::t_out_item o_out_item
);
    import ccd_pkg::*;

    logic [7:0]  r_pend [PendDepth];
    logic [2:0]  r_pcnt, n_pcnt;
    logic [2:0]  r_elen, n_elen;
    logic [2:0]  r_inv, n_inv;
    logic        r_has_main, n_has_main;
    logic [30:0] r_cp, n_cp;
    logic        r_ok, n_ok;
    logic [2:0]  r_len, n_len;
    logic [1:0]  r_wid, n_wid;
    logic        r_end;
    logic        n_store;
    logic [2:0]  n_store_idx;

    logic [7:0]  b;
    logic [2:0]  ll;
    logic [30:0] asm_cp;
    logic [16:0] sb;
    logic [2:0]  pre;

    assign b  = i_in_item.text_byte;
    assign ll = lead_len(b);
    assign sb = sb_map(i_charset, b);

    always_comb begin
        case (r_elen)
            3'd2:    asm_cp = {20'd0, r_pend[0][4:0], b[5:0]};
            3'd3:    asm_cp = {15'd0, r_pend[0][3:0], r_pend[1][5:0], b[5:0]};
            3'd4:    asm_cp = {10'd0, r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
            3'd5:    asm_cp = {5'd0, r_pend[0][1:0], r_pend[1][5:0], r_pend[2][5:0],
                               r_pend[3][5:0], b[5:0]};
            3'd6:    asm_cp = {r_pend[0][0], r_pend[1][5:0], r_pend[2][5:0],
                               r_pend[3][5:0], r_pend[4][5:0], b[5:0]};
            default: asm_cp = 31'd0;
        endcase
    end

    always_comb begin
        n_pcnt      = r_pcnt;
        n_elen      = r_elen;
        n_has_main  = 1'b0;
        n_cp        = 31'd0;
        n_ok        = 1'b0;
        n_len       = 3'd1;
        n_wid       = 2'd0;
        n_store     = 1'b0;
        n_store_idx = r_pcnt;
        pre         = 3'd0;
        if (i_charset == CS_UTF8) begin
            if ((r_pcnt != 3'd0) && (b[7:6] == 2'b10)) begin
                if ((4'(r_pcnt) + 4'd1) == 4'(r_elen)) begin
                    n_has_main = 1'b1;
                    n_cp       = asm_cp;
                    n_ok       = 1'b1;
                    n_len      = r_elen;
                    n_wid      = cp_width(asm_cp);
                    n_pcnt     = 3'd0;
                    n_elen     = 3'd0;
                end else if (r_pcnt < 3'(PendDepth)) begin
                    n_store = 1'b1;
                    n_pcnt  = r_pcnt + 3'd1;
                end
            end else begin
                pre = r_pcnt;
                n_pcnt = 3'd0;
                n_elen = 3'd0;
                if (ll == 3'd1) begin
                    n_has_main = 1'b1;
                    n_cp       = {23'd0, b};
                    n_ok       = 1'b1;
                    n_wid      = cp_width({23'd0, b});
                end else if (ll == 3'd0) begin
                    n_has_main = 1'b1;
                end else begin
                    n_store     = 1'b1;
                    n_store_idx = 3'd0;
                    n_pcnt      = 3'd1;
                    n_elen      = ll;
                end
            end
            // end of text: flush what is still buffered
            if (i_in_item.text_end) begin
                pre    = pre + n_pcnt;
                n_pcnt = 3'd0;
                n_elen = 3'd0;
            end
        end else begin
            pre        = r_pcnt;
            n_pcnt     = 3'd0;
            n_elen     = 3'd0;
            n_has_main = 1'b1;
            n_ok       = sb[16];
            n_cp       = sb[16] ? {15'd0, sb[15:0]} : 31'd0;
            n_wid      = sb[16] ? 2'd1 : 2'd0;
        end
        n_inv = pre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt     <= 3'd0;
            r_elen     <= 3'd0;
            r_inv      <= 3'd0;
            r_has_main <= 1'b0;
        end else if (i_cmd.load) begin
            r_pcnt     <= n_pcnt;
            r_elen     <= n_elen;
            r_inv      <= n_inv;
            r_has_main <= n_has_main;
        end else if (i_cmd.pop) begin
            if (r_inv != 3'd0) r_inv <= r_inv - 3'd1;
            else               r_has_main <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cp  <= n_cp;
            r_ok  <= n_ok;
            r_len <= n_len;
            r_wid <= n_wid;
            r_end <= i_in_item.text_end;
            if (n_store) r_pend[n_store_idx] <= b;
        end
    end

    always_comb begin
        o_sts.any  = (r_inv != 3'd0) || r_has_main;
        o_sts.last = ((r_inv == 3'd1) && !r_has_main) || ((r_inv == 3'd0) && r_has_main);
        if (r_inv != 3'd0) begin
            o_out_item.code_point    = 31'd0;
            o_out_item.point_valid   = 1'b0;
            o_out_item.char_bytes    = 3'd1;
            o_out_item.display_width = 2'd0;
        end else begin
            o_out_item.code_point    = r_cp;
            o_out_item.point_valid   = r_ok;
            o_out_item.char_bytes    = r_len;
            o_out_item.display_width = r_wid;
        end
        o_out_item.run_last   = o_sts.last;
        o_out_item.final_char = o_sts.last && r_end;
    end

endmodule

[rtl/core/charset_char_decoder.sv]
// Top level of the charset character decoder: register port, controller and datapath.
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_ready     i_in_item  (text_byte, text_end)
//  out       source     o_out_valid / i_out_ready   o_out_item (one decoded character)
//  config    APB slave  psel, penable, pwrite       paddr, pwdata, prdata
//
// An accepted byte item is followed by the results it yields, all delivered before the next item is taken;
// the result queue in the datapath delivers one result per cycle while the output side is ready.
// A byte that yields nothing still passes through the emit state before the next item is taken.
// Reset is synchronous and clears the buffer count, pending length and charset.
// While the output side stalls the current result holds and no new item is taken.
module charset_char_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccd_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ccd_pkg::*;

    logic [2:0] r_charset;
    t_ccd_cmd   cmd;
    t_ccd_sts   sts;
    logic       reg_hit;

    // only word zero holds a register; the low address bits are ignored
    assign reg_hit = (paddr[2] == REG_CHARSET);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {29'd0, r_charset} : 32'd0;

    // charset select: written on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset <= CS_UTF8;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_charset <= pwdata[2:0];
        end
    end

    ccd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ccd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_charset  (r_charset),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/core/ccd_checker.sv]
// Port-level checker of the charset character decoder and its bind.
module ccd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ccd_pkg::t_out_item o_out_item
);
    import ccd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // never take a byte while results are being delivered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    // an invalid character is one byte, zero code point, zero width
    a_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.point_valid |->
            (o_out_item.code_point == 31'd0) && (o_out_item.char_bytes == 3'd1) &&
            (o_out_item.display_width == 2'd0))
        else $error("malformed invalid result");

    // the final character closes its run
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.final_char |-> o_out_item.run_last)
        else $error("final character not last of run");

endmodule

bind charset_char_decoder ccd_checker u_ccd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
